/* hdl/crsf_pkg.sv */
// Package for the RC frame receiver: register indexes, reset values and
// field widths shared by the receiver. No dependencies.
`default_nettype none

package crsf_pkg;

    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ADDRESS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_TYPE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_ADDRESS  = 8'd200;
    localparam logic [BYTE_W-1:0] RST_WANTED_TYPE   = 8'd22;
    localparam logic [BYTE_W-1:0] RST_MAX_SIZE      = 8'd60;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS = 16'd1000;

    // input kind carried in s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // frame byte count: sync, size and type come before the body
    localparam logic [BYTE_W-1:0] HDR_BYTES = 8'd3;
    localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [TICK_W-1:0] IDLE_MAX  = 16'hFFFF;

    // result flags, highest bit first in m_tuser
    typedef struct packed {
        logic link_down_event;
        logic link_up_event;
        logic link_state;
        logic payload_valid;
    } crsf_flags_t;

endpackage

`default_nettype wire

/* hdl/crsf_rc_frame_receiver.sv */
// RC frame receiver top level: sync hunt, header check, body byte output and
// link timeout. Depends on crsf_pkg.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata rx_byte, tuser op
//  m_       out  m_tvalid/m_tready  tdata byte+index, tuser flags, tlast
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
// Per item: the frame state updates at the accepting edge and the result is
// loaded into the output register at that same edge. A new item is taken
// every cycle while the output register is empty or being drained; a stalled
// result blocks input only. Reset (aresetn low, synchronous) restores the
// register defaults and the sync hunt; config writes are never stalled (cfg_ready is tied high).
`default_nettype none

module crsf_rc_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] payload_byte, [15:8] payload_index
    output logic [3:0]       m_tuser,   // [0] payload_valid, [1] link_state,
                                        // [2] link_up_event, [3] link_down_event
    output logic             m_tlast,   // frame_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [crsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import crsf_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SIZE = 2'd1,
        PH_TYPE = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    logic [BYTE_W-1:0] sync_address_reg;
    logic [BYTE_W-1:0] wanted_type_reg;
    logic [BYTE_W-1:0] max_size_reg;
    logic [TICK_W-1:0] timeout_ticks_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0] frame_length_reg, frame_length_next;
    logic [TICK_W-1:0] idle_count_reg, idle_count_next;
    logic              link_reg, link_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [BYTE_W-1:0] out_index_reg, out_index_next;
    logic              out_last_reg, out_last_next;
    crsf_flags_t       out_flags_reg, out_flags_next;

    logic in_accept;
    logic body_last;
    logic link_pre;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // frame ends once the count including this byte reaches size+2, or the count is at its top
    assign body_last = (({1'b0, byte_count_reg} + 9'd1) >= ({1'b0, frame_length_reg} + 9'd2))
                    || (byte_count_reg == COUNT_MAX);

    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        idle_count_next   = idle_count_reg;
        link_pre          = link_reg;
        out_byte_next     = '0;
        out_index_next    = '0;
        out_last_next     = 1'b0;
        out_flags_next    = '0;

        if (s_tuser == OP_BYTE) begin
            idle_count_next = '0;
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_tdata == sync_address_reg) begin
                        byte_count_next = 8'd1;
                        phase_next      = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    if (s_tdata > max_size_reg) begin
                        phase_next      = PH_HUNT;
                        byte_count_next = '0;
                    end else begin
                        frame_length_next = s_tdata;
                        byte_count_next   = 8'd2;
                        phase_next        = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (s_tdata != wanted_type_reg) begin
                        phase_next      = PH_HUNT;
                        byte_count_next = '0;
                    end else begin
                        byte_count_next = HDR_BYTES;
                        phase_next      = PH_BODY;
                    end
                end
                PH_BODY: begin
                    out_flags_next.payload_valid = 1'b1;
                    out_byte_next  = s_tdata;
                    out_index_next = (byte_count_reg >= HDR_BYTES)
                                   ? byte_count_reg - HDR_BYTES : '0;
                    if (body_last) begin
                        out_last_next   = 1'b1;
                        phase_next      = PH_HUNT;
                        byte_count_next = '0;
                    end else begin
                        byte_count_next = byte_count_reg + 8'd1;
                    end
                    if (!link_reg) begin
                        link_pre                     = 1'b1;
                        out_flags_next.link_up_event = 1'b1;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end else if (idle_count_reg != IDLE_MAX) begin
            idle_count_next = idle_count_reg + 16'd1;
        end

        link_next = link_pre;
        // a received byte clears the idle count, so only a tick can time out
        if (link_pre && (idle_count_next > timeout_ticks_reg)) begin
            phase_next                     = PH_HUNT;
            byte_count_next                = '0;
            link_next                      = 1'b0;
            out_flags_next.link_down_event = 1'b1;
        end
        out_flags_next.link_state = link_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_address_reg  <= RST_SYNC_ADDRESS;
            wanted_type_reg   <= RST_WANTED_TYPE;
            max_size_reg      <= RST_MAX_SIZE;
            timeout_ticks_reg <= RST_TIMEOUT_TICKS;
            phase_reg         <= PH_HUNT;
            byte_count_reg    <= '0;
            frame_length_reg  <= '0;
            idle_count_reg    <= '0;
            link_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SYNC_ADDRESS:  sync_address_reg  <= cfg_data[BYTE_W-1:0];
                    REG_WANTED_TYPE:   wanted_type_reg   <= cfg_data[BYTE_W-1:0];
                    REG_MAX_SIZE:      max_size_reg      <= cfg_data[BYTE_W-1:0];
                    REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                frame_length_reg <= frame_length_next;
                idle_count_reg   <= idle_count_next;
                link_reg         <= link_next;
                out_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_byte_reg  <= out_byte_next;
            out_index_reg <= out_index_next;
            out_last_reg  <= out_last_next;
            out_flags_reg <= out_flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_byte_reg};
    assign m_tuser  = out_flags_reg;
    assign m_tlast  = out_last_reg;

    a_last_is_body: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_flags_reg.payload_valid)
        else $error("frame end marked on a non-body item");

    a_events_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_flags_reg.link_up_event && out_flags_reg.link_down_event))
        else $error("link up and down on the same item");

    a_link_matches_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_flags_reg.link_state == link_reg))
        else $error("reported link state differs from held state");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(phase_reg) && $stable(idle_count_reg))
        else $error("frame state moved while the result was stalled");

endmodule

`default_nettype wire

/* dv/tb_crsf_rc_frame_receiver.sv */
// Self-checking testbench for crsf_rc_frame_receiver: a directed table, then
// random frames, noise and tick bursts over several register settings.
// Depends on crsf_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module tb_crsf_rc_frame_receiver;
    import crsf_pkg::*;

    // longest quiet stretch is the LONG_HOLD result-side stall plus a few drains
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 150;

    typedef enum logic [1:0] {HUNT_SYNC, READ_SIZE, READ_TYPE, READ_BODY} rx_phase_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_last;
        logic        link_state;
        logic        link_up_event;
        logic        link_down_event;
    } rc_result_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        typed;     // use the written-in result instead of the predictor
        rc_result_t  want;
    } stim_row_t;

    localparam rc_result_t NO_RESULT = '0;
    // first body byte of a short frame at reset settings: link comes up, frame ends
    localparam rc_result_t SHORT_FRAME_UP = '{payload_valid: 1'b1, payload_byte: 8'hFF,
                                              payload_index: 8'd0, frame_last: 1'b1,
                                              link_state: 1'b1, link_up_event: 1'b1,
                                              link_down_event: 1'b0};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    crsf_rc_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver shadow state and registers
    rx_phase_t    rx_phase     = HUNT_SYNC;
    logic [7:0]   frame_bytes  = '0;
    logic [7:0]   size_field   = '0;
    logic [15:0]  idle_ticks   = '0;
    logic         link_up      = 1'b0;
    logic [7:0]   sync_byte    = RST_SYNC_ADDRESS;
    logic [7:0]   type_byte    = RST_WANTED_TYPE;
    logic [7:0]   size_limit   = RST_MAX_SIZE;
    logic [15:0]  timeout_lim  = RST_TIMEOUT_TICKS;

    rc_result_t   pending_results[$];
    int           items_sent    = 0;
    int           results_taken = 0;
    int           mismatches    = 0;
    int           quiet_cycles  = 0;

    stim_row_t directed_rows [24] = '{
        '{OP_TICK, 8'hFF, 1'b1, NO_RESULT},      // tick while hunting
        '{OP_BYTE, 8'h00, 1'b1, NO_RESULT},      // noise
        '{OP_BYTE, 8'd200, 1'b1, NO_RESULT},     // sync
        '{OP_BYTE, 8'd61, 1'b1, NO_RESULT},      // size above limit
        '{OP_BYTE, 8'd200, 1'b1, NO_RESULT},
        '{OP_BYTE, 8'd0, 1'b1, NO_RESULT},
        '{OP_BYTE, 8'd21, 1'b1, NO_RESULT},      // wrong type
        '{OP_BYTE, 8'd200, 1'b1, NO_RESULT},
        '{OP_BYTE, 8'd0, 1'b1, NO_RESULT},       // size 0: one body byte
        '{OP_BYTE, 8'd22, 1'b1, NO_RESULT},
        '{OP_BYTE, 8'hFF, 1'b1, SHORT_FRAME_UP},
        '{OP_BYTE, 8'd200, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'd3, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'd22, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'hA5, 1'b0, NO_RESULT},
        '{OP_TICK, 8'h00, 1'b0, NO_RESULT},      // tick inside a frame
        '{OP_BYTE, 8'h5A, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'd200, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'd60, 1'b0, NO_RESULT},      // largest accepted size
        '{OP_BYTE, 8'd22, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'h80, 1'b0, NO_RESULT},
        '{OP_BYTE, 8'd200, 1'b0, NO_RESULT},     // sync value as body data
        '{OP_TICK, 8'h7F, 1'b0, NO_RESULT}
    };

    function automatic void drop_to_hunt();
        rx_phase    = HUNT_SYNC;
        frame_bytes = '0;
    endfunction

    function automatic rc_result_t predict_rc_result(input logic op, input logic [7:0] b);
        rc_result_t r;
        r = '0;
        if (op == OP_BYTE) begin
            idle_ticks = '0;
            case (rx_phase)
                HUNT_SYNC: begin
                    if (b == sync_byte) begin
                        frame_bytes = 8'd1;
                        rx_phase    = READ_SIZE;
                    end
                end
                READ_SIZE: begin
                    if (b > size_limit) begin
                        drop_to_hunt();
                    end else begin
                        size_field  = b;
                        frame_bytes = 8'd2;
                        rx_phase    = READ_TYPE;
                    end
                end
                READ_TYPE: begin
                    if (b != type_byte) begin
                        drop_to_hunt();
                    end else begin
                        frame_bytes = HDR_BYTES;
                        rx_phase    = READ_BODY;
                    end
                end
                default: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = frame_bytes - HDR_BYTES;
                    // count includes this byte; a frame also ends when the counter is at its top
                    if (int'(frame_bytes) + 1 >= int'(size_field) + 2
                            || frame_bytes == COUNT_MAX) begin
                        r.frame_last = 1'b1;
                        drop_to_hunt();
                    end else begin
                        frame_bytes = frame_bytes + 8'd1;
                    end
                    if (!link_up) begin
                        link_up         = 1'b1;
                        r.link_up_event = 1'b1;
                    end
                end
            endcase
        end else if (idle_ticks != IDLE_MAX) begin
            idle_ticks = idle_ticks + 16'd1;
        end
        if (link_up && idle_ticks > timeout_lim) begin
            drop_to_hunt();
            link_up           = 1'b0;
            r.link_down_event = 1'b1;
        end
        r.link_state = link_up;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                             input rc_result_t want);
        int gap;
        rc_result_t predicted;
        // every fourth run of 64 items goes without gaps
        gap = (((items_sent >> 6) % 4) == 3) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_rc_result(op, b);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b, 1'b0, NO_RESULT);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    endtask

    // mostly well-formed frames with random content, the rest noise and ticks
    task automatic send_traffic(input int n);
        int sent;
        int kind;
        int size_b;
        int body_n;
        int cap;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                cap    = (size_limit < 16) ? int'(size_limit) : 16;
                size_b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, cap);
                send_byte(sync_byte);
                send_byte(8'(size_b));
                send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : type_byte);
                body_n = (size_b <= 2) ? 1 : size_b - 1;
                if ($urandom_range(0, 9) == 0)
                    body_n = $urandom_range(0, body_n);     // truncated frame
                for (int i = 0; i < body_n; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_tick();
                        sent++;
                    end
                    send_byte(8'($urandom));
                end
                sent += 3 + body_n;
            end else if (kind < 85) begin
                cap = $urandom_range(1, 4);
                for (int i = 0; i < cap; i++)
                    send_byte(8'($urandom));
                sent += cap;
            end else begin
                cap = (timeout_lim < 40) ? $urandom_range(1, int'(timeout_lim) + 3)
                                         : $urandom_range(1, 4);
                for (int i = 0; i < cap; i++)
                    send_tick();
                sent += cap;
            end
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SYNC_ADDRESS:  sync_byte   = data[7:0];
            REG_WANTED_TYPE:   type_byte   = data[7:0];
            REG_MAX_SIZE:      size_limit  = data[7:0];
            REG_TIMEOUT_TICKS: timeout_lim = data;
            default: ;
        endcase
    endtask

    // upper data bits on the byte registers are random and must be dropped
    task automatic reconfigure(input logic [7:0] sync_v, input logic [7:0] type_v,
                               input logic [7:0] size_v, input logic [15:0] timeout_v,
                               input logic [CFG_IDX_W-1:0] unused_idx);
        wait_all_results();
        cfg_write(REG_SYNC_ADDRESS, {8'($urandom), sync_v});
        cfg_write(REG_WANTED_TYPE, {8'($urandom), type_v});
        cfg_write(REG_MAX_SIZE, {8'($urandom), size_v});
        cfg_write(REG_TIMEOUT_TICKS, timeout_v);
        cfg_write(unused_idx, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        rc_result_t  want;
        crsf_flags_t flags;
        flags = crsf_flags_t'(m_tuser);
        if (pending_results.size() == 0) begin
            $error("result item with nothing pending");
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            compare_field("payload_valid", want.payload_valid, flags.payload_valid);
            compare_field("payload_byte", want.payload_byte, m_tdata[7:0]);
            compare_field("payload_index", want.payload_index, m_tdata[15:8]);
            compare_field("frame_last", want.frame_last, m_tlast);
            compare_field("link_state", want.link_state, flags.link_state);
            compare_field("link_up_event", want.link_up_event, flags.link_up_event);
            compare_field("link_down_event", want.link_down_event, flags.link_down_event);
        end
    endtask

    // result side: random stalls, gap-free runs, and one long hold that backs up the input
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (results_taken == HOLD_AT_RESULT)
                stall = LONG_HOLD;
            else
                stall = (((results_taken >> 6) % 4) == 1) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result();
            results_taken++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
        send_traffic(150);

        // low extremes: zero timeout drops the link on any tick
        reconfigure(8'd0, 8'd255, 8'd0, 16'd0, 8'hFF);
        send_traffic(170);

        // high extremes: timeout never fires, largest frame hits the counter limit
        reconfigure(8'd255, 8'd0, 8'd255, 16'hFFFF, 8'($urandom_range(4, 255)));
        send_traffic(150);
        send_byte(8'd255);
        send_byte(8'd255);
        send_byte(8'd0);
        for (int i = 0; i < 254; i++)
            send_byte(8'($urandom));
        // long idle stretch with the link up
        for (int i = 0; i < 64; i++)
            send_tick();

        // long idle count exceeds a small timeout on the very next tick
        reconfigure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 24)), 16'd5,
                    8'($urandom_range(4, 255)));
        send_tick();
        send_traffic(160);

        for (int k = 4; k < 9; k++) begin
            reconfigure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 30)),
                        (k == 6) ? 16'($urandom) : 16'($urandom_range(0, 30)),
                        8'($urandom_range(4, 255)));
            send_traffic(155);
        end

        wait_all_results();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* crsf_rc_frame_receiver.f */
hdl/crsf_pkg.sv
hdl/crsf_rc_frame_receiver.sv
dv/tb_crsf_rc_frame_receiver.sv
